// File: hdl/ozh_pkg.sv
`default_nettype none

package ozh_pkg;

  localparam int unsigned DepthW = 16;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 3;

  // zone codes
  localparam logic [1:0] ZONE_CLEAR  = 2'd0;
  localparam logic [1:0] ZONE_LEFT   = 2'd1;
  localparam logic [1:0] ZONE_RIGHT  = 2'd2;
  localparam logic [1:0] ZONE_CORNER = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_EMERGENCY  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FRONT_ENTR = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRONT_EXIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SIDE_ENTR  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SIDE_EXIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MIN_VALID  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_MIN_NEAR   = 3'd6;

  typedef struct packed {
    logic [CfgW-1:0] emergency_mm;
    logic [CfgW-1:0] front_enter_mm;
    logic [CfgW-1:0] front_exit_mm;
    logic [CfgW-1:0] side_enter_mm;
    logic [CfgW-1:0] side_exit_mm;
    logic [CfgW-1:0] min_valid_pixels;
    logic [CfgW-1:0] min_near_pixels;
  } cfg_t;

  typedef struct packed {
    logic [DepthW-1:0] depth_mm;
    logic [CountW-1:0] near_pix;
    logic [CountW-1:0] valid_pix;
  } region_t;

  typedef struct packed {
    region_t          front;
    region_t          left;
    region_t          right;
    logic [TimeW-1:0] frame_time_ms;
  } frame_t;

  typedef struct packed {
    logic [1:0]       zone_state;
    logic [7:0]       clear_cnt;
    logic [1:0]       held_zone;
    logic [TimeW-1:0] held_since_ms;
  } zstate_t;

  typedef struct packed {
    logic [1:0]        zone;
    logic [1:0]        raw_zone;
    logic [DepthW-1:0] front_distance_mm;
  } result_t;

  function automatic logic region_hit(region_t r, logic [CfgW-1:0] thr, cfg_t cfg);
    region_hit = (r.depth_mm != '0) && (r.valid_pix >= cfg.min_valid_pixels) &&
                 (r.depth_mm < thr) && (r.near_pix >= cfg.min_near_pixels);
  endfunction

endpackage

`default_nettype wire

// File: hdl/ozh_cfg_regs.sv
`default_nettype none

module ozh_cfg_regs
  import ozh_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emergency_mm     <= 16'd300;
      cfg_q.front_enter_mm   <= 16'd600;
      cfg_q.front_exit_mm    <= 16'd800;
      cfg_q.side_enter_mm    <= 16'd600;
      cfg_q.side_exit_mm     <= 16'd800;
      cfg_q.min_valid_pixels <= 16'd60;
      cfg_q.min_near_pixels  <= 16'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_EMERGENCY:  cfg_q.emergency_mm     <= cfg_wdata_i;
        CFG_FRONT_ENTR: cfg_q.front_enter_mm   <= cfg_wdata_i;
        CFG_FRONT_EXIT: cfg_q.front_exit_mm    <= cfg_wdata_i;
        CFG_SIDE_ENTR:  cfg_q.side_enter_mm    <= cfg_wdata_i;
        CFG_SIDE_EXIT:  cfg_q.side_exit_mm     <= cfg_wdata_i;
        CFG_MIN_VALID:  cfg_q.min_valid_pixels <= cfg_wdata_i;
        CFG_MIN_NEAR:   cfg_q.min_near_pixels  <= cfg_wdata_i;
        default: ; // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hdl/ozh_decide.sv
`default_nettype none

module ozh_decide
  import ozh_pkg::*;
#(
  parameter int unsigned CORNER_CLEAR_FRAMES = 1,
  parameter int unsigned SIDE_CLEAR_FRAMES   = 2,
  parameter int unsigned CORNER_LINGER_MS    = 30,
  parameter int unsigned SIDE_LINGER_MS      = 50
) (
  input  cfg_t    cfg_i,
  input  frame_t  frame_i,
  input  zstate_t state_i,
  output zstate_t state_o,
  output result_t result_o
);

  localparam logic [7:0] CornerNeed =
    (CORNER_CLEAR_FRAMES < 1) ? 8'd1 : 8'(CORNER_CLEAR_FRAMES);
  localparam logic [7:0] SideNeed =
    (SIDE_CLEAR_FRAMES < 1) ? 8'd1 : 8'(SIDE_CLEAR_FRAMES);
  localparam logic [TimeW-1:0] CornerHold = TimeW'(CORNER_LINGER_MS);
  localparam logic [TimeW-1:0] SideHold   = TimeW'(SIDE_LINGER_MS);

  logic             emerg_hit;
  logic             fc, lc, rc;
  logic             fe, le, re;
  logic [7:0]       cnt_inc;
  logic [7:0]       need;
  logic [1:0]       raw;
  logic [TimeW-1:0] age;
  logic [TimeW-1:0] hold;

  always_comb begin
    emerg_hit = region_hit(frame_i.front, cfg_i.emergency_mm, cfg_i);
    fc = region_hit(frame_i.front, cfg_i.front_exit_mm, cfg_i);
    lc = region_hit(frame_i.left, cfg_i.side_exit_mm, cfg_i);
    rc = region_hit(frame_i.right, cfg_i.side_exit_mm, cfg_i);
    fe = region_hit(frame_i.front, cfg_i.front_enter_mm, cfg_i);
    le = region_hit(frame_i.left, cfg_i.side_enter_mm, cfg_i);
    re = region_hit(frame_i.right, cfg_i.side_enter_mm, cfg_i);
    cnt_inc = state_i.clear_cnt + 8'd1;
    need = (state_i.zone_state == ZONE_CORNER) ? CornerNeed : SideNeed;

    state_o = state_i;
    priority if (emerg_hit) begin
      state_o.zone_state = ZONE_CORNER;
      state_o.clear_cnt  = '0;
    end else if (state_i.zone_state != ZONE_CLEAR) begin
      if (fc || lc || rc) begin
        state_o.clear_cnt = '0;
        priority if (fc) state_o.zone_state = ZONE_CORNER;
        else if (lc && !rc) state_o.zone_state = ZONE_LEFT;
        else if (rc && !lc) state_o.zone_state = ZONE_RIGHT;
        else state_o.zone_state =
          (frame_i.left.depth_mm <= frame_i.right.depth_mm) ? ZONE_LEFT : ZONE_RIGHT;
      end else if (cnt_inc >= need) begin
        state_o.zone_state = ZONE_CLEAR;
        state_o.clear_cnt  = '0;
      end else begin
        state_o.clear_cnt = cnt_inc;
      end
    end else begin
      priority if (fe) begin
        state_o.zone_state = ZONE_CORNER;
        state_o.clear_cnt  = '0;
      end else if (le) begin
        state_o.zone_state = ZONE_LEFT;
        state_o.clear_cnt  = '0;
      end else if (re) begin
        state_o.zone_state = ZONE_RIGHT;
        state_o.clear_cnt  = '0;
      end else begin
        state_o.clear_cnt = state_i.clear_cnt;
      end
    end

    // time hold on the last obstacle zone
    raw  = state_o.zone_state;
    age  = frame_i.frame_time_ms - state_i.held_since_ms;
    hold = (state_i.held_zone == ZONE_CORNER) ? CornerHold : SideHold;
    result_o.raw_zone          = raw;
    result_o.front_distance_mm = frame_i.front.depth_mm;
    if (raw != ZONE_CLEAR) begin
      state_o.held_zone     = raw;
      state_o.held_since_ms = frame_i.frame_time_ms;
      result_o.zone         = raw;
    end else begin
      result_o.zone = (age < hold) ? state_i.held_zone : ZONE_CLEAR;
    end
  end

endmodule

`default_nettype wire

// File: hdl/obstacle_zone_hysteresis.sv
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------------------------
// frame   | in        | in_valid_i/in_stall_o | three region stats, frame_time_ms_i
// result  | out       | out_valid_o/out_stall_i | zone_o, raw_zone_o, front_distance_mm_o
// config  | in        | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// one frame transaction per cycle sustained while the result side does not stall
// the path is input register, zone decision and hold compare, result register
// the zone state advances only when a frame moves from the input register to the result
// rst_ni (async, active low) sets state clear, held zone corner, registers to defaults
// a stalled result holds the input register; in_stall_o follows out_stall_i combinationally
`default_nettype none

module obstacle_zone_hysteresis
  import ozh_pkg::*;
#(
  parameter int unsigned CORNER_CLEAR_FRAMES = 1,
  parameter int unsigned SIDE_CLEAR_FRAMES   = 2,
  parameter int unsigned CORNER_LINGER_MS    = 30,
  parameter int unsigned SIDE_LINGER_MS      = 50
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_wdata_i,
  // frame channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [DepthW-1:0]  front_depth_mm_i,
  input  wire logic [CountW-1:0]  front_near_i,
  input  wire logic [CountW-1:0]  front_valid_i,
  input  wire logic [DepthW-1:0]  left_depth_mm_i,
  input  wire logic [CountW-1:0]  left_near_i,
  input  wire logic [CountW-1:0]  left_valid_i,
  input  wire logic [DepthW-1:0]  right_depth_mm_i,
  input  wire logic [CountW-1:0]  right_near_i,
  input  wire logic [CountW-1:0]  right_valid_i,
  input  wire logic [TimeW-1:0]   frame_time_ms_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              zone_o,
  output logic [1:0]              raw_zone_o,
  output logic [DepthW-1:0]       front_distance_mm_o
);

  cfg_t    cfg;
  frame_t  frame_in;
  frame_t  frame_q;
  logic    frame_vld_q;
  zstate_t state_q, state_d;
  result_t result_d, result_q;
  logic    out_vld_q;
  logic    out_free;
  logic    advance;
  logic    in_take;

  ozh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ozh_decide #(
    .CORNER_CLEAR_FRAMES (CORNER_CLEAR_FRAMES),
    .SIDE_CLEAR_FRAMES   (SIDE_CLEAR_FRAMES),
    .CORNER_LINGER_MS    (CORNER_LINGER_MS),
    .SIDE_LINGER_MS      (SIDE_LINGER_MS)
  ) u_decide (
    .cfg_i    (cfg),
    .frame_i  (frame_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // pack the frame ports
  assign frame_in.front.depth_mm  = front_depth_mm_i;
  assign frame_in.front.near_pix  = front_near_i;
  assign frame_in.front.valid_pix = front_valid_i;
  assign frame_in.left.depth_mm   = left_depth_mm_i;
  assign frame_in.left.near_pix   = left_near_i;
  assign frame_in.left.valid_pix  = left_valid_i;
  assign frame_in.right.depth_mm  = right_depth_mm_i;
  assign frame_in.right.near_pix  = right_near_i;
  assign frame_in.right.valid_pix = right_valid_i;
  assign frame_in.frame_time_ms   = frame_time_ms_i;

  // result register is free when empty or being drained this cycle
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = frame_vld_q && out_free;
  assign in_stall_o = frame_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_vld_q <= 1'b0;
    end else if (in_take) begin
      frame_vld_q <= 1'b1;
    end else if (advance) begin
      frame_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      frame_q <= frame_in;
    end
  end

  // zone state, updated once per frame that reaches the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.zone_state    <= ZONE_CLEAR;
      state_q.clear_cnt     <= '0;
      state_q.held_zone     <= ZONE_CORNER;
      state_q.held_since_ms <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign zone_o              = result_q.zone;
  assign raw_zone_o          = result_q.raw_zone;
  assign front_distance_mm_o = result_q.front_distance_mm;

  // a non-clear raw zone is never overridden by the hold
  a_raw_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && result_q.raw_zone != ZONE_CLEAR) |-> (result_q.zone == result_q.raw_zone))
    else $error("held zone differs from a non-clear raw zone");

  // the clear counter only runs in an obstacle state
  a_cnt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.zone_state == ZONE_CLEAR) |-> (state_q.clear_cnt == '0))
    else $error("clear frame counter nonzero in clear state");

  // the held zone is always an obstacle zone
  a_held_nonclear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held_zone != ZONE_CLEAR)
    else $error("held zone is clear");

  // a stall on the frame side only comes from a full input register behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (frame_vld_q && out_vld_q && out_stall_i))
    else $error("frame side stalled without cause");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ozh_pkg::*;

  // block parameters, passed to the instance so the predictor agrees with them
  localparam int unsigned CornerClearFrames = 1;
  localparam int unsigned SideClearFrames   = 2;
  localparam int unsigned CornerHoldMs      = 30;
  localparam int unsigned SideHoldMs        = 50;

  // index past the last register, writes to it must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 3'd7;

  localparam int unsigned IdlePct     = 21;
  localparam int unsigned HoldoffLen  = 60;
  localparam int unsigned ShownErrors = 10;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgW-1:0]     cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [DepthW-1:0]   front_depth_mm_i = '0;
  logic [CountW-1:0]   front_near_i = '0;
  logic [CountW-1:0]   front_valid_i = '0;
  logic [DepthW-1:0]   left_depth_mm_i = '0;
  logic [CountW-1:0]   left_near_i = '0;
  logic [CountW-1:0]   left_valid_i = '0;
  logic [DepthW-1:0]   right_depth_mm_i = '0;
  logic [CountW-1:0]   right_near_i = '0;
  logic [CountW-1:0]   right_valid_i = '0;
  logic [TimeW-1:0]    frame_time_ms_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          zone_o;
  logic [1:0]          raw_zone_o;
  logic [DepthW-1:0]   front_distance_mm_o;

  obstacle_zone_hysteresis #(
    .CORNER_CLEAR_FRAMES(CornerClearFrames),
    .SIDE_CLEAR_FRAMES  (SideClearFrames),
    .CORNER_LINGER_MS   (CornerHoldMs),
    .SIDE_LINGER_MS     (SideHoldMs)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .front_depth_mm_i   (front_depth_mm_i),
    .front_near_i       (front_near_i),
    .front_valid_i      (front_valid_i),
    .left_depth_mm_i    (left_depth_mm_i),
    .left_near_i        (left_near_i),
    .left_valid_i       (left_valid_i),
    .right_depth_mm_i   (right_depth_mm_i),
    .right_near_i       (right_near_i),
    .right_valid_i      (right_valid_i),
    .frame_time_ms_i    (frame_time_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .zone_o             (zone_o),
    .raw_zone_o         (raw_zone_o),
    .front_distance_mm_o(front_distance_mm_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow of the register file and of the zone tracking state
  cfg_t        thr_cfg;
  logic [1:0]  zone_now;
  logic [7:0]  clear_run;
  logic [1:0]  hold_zone;
  logic [31:0] hold_start;

  frame_t      frame_pending_q[$];
  result_t     zone_expect_q[$];
  frame_t      offered;
  bit          frame_taken = 1'b0;
  bit          steady = 1'b0;
  bit          holdoff_req = 1'b0;
  int unsigned holdoff_left = 0;
  int unsigned mismatches = 0;
  logic [31:0] now_ms = '0;

  // obstacle test for one region against a given depth threshold
  function automatic logic obstacle(region_t r, logic [CfgW-1:0] thr);
    return r.depth_mm != '0 && r.depth_mm < thr &&
           r.valid_pix >= thr_cfg.min_valid_pixels &&
           r.near_pix >= thr_cfg.min_near_pixels;
  endfunction

  // advance the zone state by one frame and queue the result it should give
  task automatic predict_zone(input frame_t f);
    logic        fc, lc, rc;
    logic [7:0]  need;
    logic [31:0] age;
    logic [31:0] hold_len;
    result_t     r;
    if (obstacle(f.front, thr_cfg.emergency_mm)) begin
      // emergency front obstacle wins over everything
      zone_now  = ZONE_CORNER;
      clear_run = '0;
    end else if (zone_now != ZONE_CLEAR) begin
      // already in an obstacle zone: exit thresholds apply
      fc = obstacle(f.front, thr_cfg.front_exit_mm);
      lc = obstacle(f.left, thr_cfg.side_exit_mm);
      rc = obstacle(f.right, thr_cfg.side_exit_mm);
      if (fc || lc || rc) begin
        clear_run = '0;
        if (fc) zone_now = ZONE_CORNER;
        else if (lc && !rc) zone_now = ZONE_LEFT;
        else if (rc && !lc) zone_now = ZONE_RIGHT;
        // both sides: nearer one, ties to the left
        else zone_now = (f.left.depth_mm <= f.right.depth_mm) ? ZONE_LEFT : ZONE_RIGHT;
      end else begin
        need = (zone_now == ZONE_CORNER) ? 8'(CornerClearFrames) : 8'(SideClearFrames);
        if (need == '0) need = 8'd1;
        clear_run = clear_run + 8'd1;
        if (clear_run >= need) begin
          zone_now  = ZONE_CLEAR;
          clear_run = '0;
        end
      end
    end else begin
      // clear: enter thresholds, front before left before right
      if (obstacle(f.front, thr_cfg.front_enter_mm)) begin
        zone_now  = ZONE_CORNER;
        clear_run = '0;
      end else if (obstacle(f.left, thr_cfg.side_enter_mm)) begin
        zone_now  = ZONE_LEFT;
        clear_run = '0;
      end else if (obstacle(f.right, thr_cfg.side_enter_mm)) begin
        zone_now  = ZONE_RIGHT;
        clear_run = '0;
      end
    end
    r.raw_zone          = zone_now;
    r.zone              = zone_now;
    r.front_distance_mm = f.front.depth_mm;
    if (zone_now != ZONE_CLEAR) begin
      hold_zone  = zone_now;
      hold_start = f.frame_time_ms;
    end else begin
      // age wraps, so an older timestamp means no hold
      age      = f.frame_time_ms - hold_start;
      hold_len = (hold_zone == ZONE_CORNER) ? CornerHoldMs : SideHoldMs;
      if (age < hold_len) r.zone = hold_zone;
    end
    zone_expect_q.insert(zone_expect_q.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // frame driver: a new frame only after the previous one went through
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || frame_taken) begin
      frame_taken = 1'b0;
      if (frame_pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct)) begin
        offered = frame_pending_q.pop_front();
        in_valid_i       <= 1'b1;
        front_depth_mm_i <= offered.front.depth_mm;
        front_near_i     <= offered.front.near_pix;
        front_valid_i    <= offered.front.valid_pix;
        left_depth_mm_i  <= offered.left.depth_mm;
        left_near_i      <= offered.left.near_pix;
        left_valid_i     <= offered.left.valid_pix;
        right_depth_mm_i <= offered.right.depth_mm;
        right_near_i     <= offered.right.near_pix;
        right_valid_i    <= offered.right.valid_pix;
        frame_time_ms_i  <= offered.frame_time_ms;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // frame transaction accepted: run the predictor on it
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_zone(offered);
      frame_taken = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side stall: random, off while steady, and a long counted hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (holdoff_req) begin
      holdoff_left = HoldoffLen;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      out_stall_i <= 1'b1;
      holdoff_left = holdoff_left - 1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (zone_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("unexpected result: zone %0d raw %0d front %0d",
                   zone_o, raw_zone_o, front_distance_mm_o);
      end else begin
        want = zone_expect_q.pop_front();
        if (zone_o !== want.zone || raw_zone_o !== want.raw_zone ||
            front_distance_mm_o !== want.front_distance_mm) begin
          mismatches++;
          if (mismatches <= ShownErrors)
            $display("mismatch: zone exp %0d got %0d, raw exp %0d got %0d, front exp %0d got %0d",
                     want.zone, zone_o, want.raw_zone, raw_zone_o,
                     want.front_distance_mm, front_distance_mm_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_EMERGENCY:  thr_cfg.emergency_mm     = val;
      CFG_FRONT_ENTR: thr_cfg.front_enter_mm   = val;
      CFG_FRONT_EXIT: thr_cfg.front_exit_mm    = val;
      CFG_SIDE_ENTR:  thr_cfg.side_enter_mm    = val;
      CFG_SIDE_EXIT:  thr_cfg.side_exit_mm     = val;
      CFG_MIN_VALID:  thr_cfg.min_valid_pixels = val;
      CFG_MIN_NEAR:   thr_cfg.min_near_pixels  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender pause until the block has nothing left in flight
  task automatic wait_drained();
    do @(negedge clk_i);
    while (frame_pending_q.size() != 0 || in_valid_i || zone_expect_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic push_frame(input logic [15:0] fd, fn, fv, ld, ln, lv, rd, rn, rv,
                            input logic [31:0] t);
    frame_t f;
    f.front = '{depth_mm: fd, near_pix: fn, valid_pix: fv};
    f.left  = '{depth_mm: ld, near_pix: ln, valid_pix: lv};
    f.right = '{depth_mm: rd, near_pix: rn, valid_pix: rv};
    f.frame_time_ms = t;
    frame_pending_q.insert(frame_pending_q.size(), f);
  endtask

  // count near the configured minimum, sometimes anywhere
  function automatic logic [15:0] pick_count(logic [15:0] minv);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom);
      1:       return minv - 16'd1;
      2:       return minv;
      default: return minv + 16'($urandom_range(0, 300));
    endcase
  endfunction

  // region stats clustered around the thresholds; calm leans toward no obstacle
  function automatic region_t pick_region(bit calm, logic [15:0] enter_thr, exit_thr);
    region_t     r;
    int unsigned mode;
    mode = calm ? (($urandom_range(0, 3) == 0) ? 0 : 7) : $urandom_range(0, 9);
    case (mode)
      0:       r.depth_mm = '0;
      1:       r.depth_mm = 16'($urandom);
      2:       r.depth_mm = thr_cfg.emergency_mm + 16'($urandom_range(0, 4)) - 16'd2;
      3, 4:    r.depth_mm = enter_thr + 16'($urandom_range(0, 4)) - 16'd2;
      5, 6:    r.depth_mm = exit_thr + 16'($urandom_range(0, 4)) - 16'd2;
      default: r.depth_mm = exit_thr + 16'($urandom_range(0, 3000));
    endcase
    r.near_pix  = pick_count(thr_cfg.min_near_pixels);
    r.valid_pix = pick_count(thr_cfg.min_valid_pixels);
    return r;
  endfunction

  // well-formed frame runs with mostly rising time, plus short calm stretches
  // so the clear-frame count and the time hold both get exercised
  task automatic queue_random(input int unsigned n);
    frame_t      f;
    int unsigned calm_left;
    int unsigned pick;
    calm_left = 0;
    repeat (n) begin
      if (calm_left == 0 && $urandom_range(0, 99) < 15) calm_left = $urandom_range(1, 4);
      f.front = pick_region(calm_left != 0, thr_cfg.front_enter_mm, thr_cfg.front_exit_mm);
      f.left  = pick_region(calm_left != 0, thr_cfg.side_enter_mm, thr_cfg.side_exit_mm);
      f.right = pick_region(calm_left != 0, thr_cfg.side_enter_mm, thr_cfg.side_exit_mm);
      if (calm_left != 0) calm_left--;
      pick = $urandom_range(0, 99);
      if (pick < 90) now_ms = now_ms + $urandom_range(0, 25);
      else if (pick < 95) now_ms = now_ms + $urandom_range(26, 120);
      else if (pick < 98) now_ms = now_ms - $urandom_range(1, 50);
      else now_ms = $urandom;
      f.frame_time_ms = now_ms;
      frame_pending_q.insert(frame_pending_q.size(), f);
    end
  endtask

  task automatic load_settings(input int unsigned phase);
    logic [15:0] ent;
    case (phase)
      0: ;
      1: begin
        // all thresholds and minimums at zero
        write_reg(CFG_EMERGENCY, '0);
        write_reg(CFG_FRONT_ENTR, '0);
        write_reg(CFG_FRONT_EXIT, '0);
        write_reg(CFG_SIDE_ENTR, '0);
        write_reg(CFG_SIDE_EXIT, '0);
        write_reg(CFG_MIN_VALID, '0);
        write_reg(CFG_MIN_NEAR, '0);
        write_reg(CFG_SPARE, 16'($urandom));
      end
      2: begin
        // everything at the top of its range
        write_reg(CFG_EMERGENCY, '1);
        write_reg(CFG_FRONT_ENTR, '1);
        write_reg(CFG_FRONT_EXIT, '1);
        write_reg(CFG_SIDE_ENTR, '1);
        write_reg(CFG_SIDE_EXIT, '1);
        write_reg(CFG_MIN_VALID, '1);
        write_reg(CFG_MIN_NEAR, '1);
      end
      6: begin
        write_reg(CFG_EMERGENCY, 16'($urandom));
        write_reg(CFG_FRONT_ENTR, 16'($urandom));
        write_reg(CFG_FRONT_EXIT, 16'($urandom));
        write_reg(CFG_SIDE_ENTR, 16'($urandom));
        write_reg(CFG_SIDE_EXIT, 16'($urandom));
        write_reg(CFG_MIN_VALID, 16'($urandom_range(0, 400)));
        write_reg(CFG_MIN_NEAR, 16'($urandom_range(0, 40)));
        write_reg(CFG_SPARE, 16'($urandom));
      end
      default: begin
        // plausible tuning: exit at or above enter, emergency drawn from 0 to 1000
        ent = 16'($urandom_range(200, 1500));
        write_reg(CFG_EMERGENCY, 16'($urandom_range(0, 1000)));
        write_reg(CFG_FRONT_ENTR, ent);
        write_reg(CFG_FRONT_EXIT, ent + 16'($urandom_range(0, 500)));
        ent = 16'($urandom_range(200, 1500));
        write_reg(CFG_SIDE_ENTR, ent);
        write_reg(CFG_SIDE_EXIT, ent + 16'($urandom_range(0, 500)));
        write_reg(CFG_MIN_VALID, 16'($urandom_range(0, 200)));
        write_reg(CFG_MIN_NEAR, 16'($urandom_range(0, 20)));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    // predictor starts from the reset values
    thr_cfg = '{emergency_mm: 16'd300, front_enter_mm: 16'd600, front_exit_mm: 16'd800,
                side_enter_mm: 16'd600, side_exit_mm: 16'd800,
                min_valid_pixels: 16'd60, min_near_pixels: 16'd4};
    zone_now   = ZONE_CLEAR;
    clear_run  = '0;
    hold_zone  = ZONE_CORNER;
    hold_start = '0;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames on the reset tuning
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);              // corner hold right after reset
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 40);             // reset hold expired
    push_frame(299, 4, 60, 0, 0, 0, 0, 0, 0, 45);          // emergency front
    push_frame(300, 4, 60, 0, 0, 0, 0, 0, 0, 50);          // front under exit threshold
    push_frame(799, 3, 60, 0, 0, 0, 0, 0, 0, 55);          // near count short, corner clears
    push_frame(0, 0, 0, 599, 4, 60, 0, 0, 0, 60);          // left enters
    push_frame(0, 0, 0, 700, 4, 60, 700, 4, 60, 65);       // both sides tie, left
    push_frame(0, 0, 0, 750, 4, 60, 700, 4, 60, 70);       // both sides, right nearer
    push_frame(0, 0, 0, 790, 4, 59, 0, 0, 0, 75);          // valid count short
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 80);             // second clear frame
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 124);            // side hold still on
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 125);            // side hold just over
    push_frame(0, 0, 0, 0, 0, 0, 599, 4, 60, 130);         // right enters
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 131);
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 132);
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 100);            // timestamp went back
    push_frame(599, 4, 60, 100, 4, 60, 0, 0, 0, 200);      // front beats left from clear
    push_frame(800, 4, 60, 0, 16'hffff, 16'hffff, 0, 0, 0, 210); // exit edge, zero depth
    push_frame(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
               16'hffff, 16'hffff, 16'hffff, 32'hffff_ffff);
    push_frame(1, 16'hffff, 16'hffff, 0, 0, 0, 0, 0, 0, 32'hffff_ffff);
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 5);              // hold across time wrap
    push_frame(0, 0, 0, 0, 0, 0, 0, 0, 0, 7);
    push_frame(0, 0, 0, 10, 4, 60, 10, 4, 60, 10);         // left first from clear
    push_frame(0, 0, 0, 600, 4, 60, 5, 4, 60, 12);         // both on exit, right nearer
    now_ms = 32'd20;
    wait_drained();

    for (int unsigned phase = 0; phase < 7; phase++) begin
      load_settings(phase);
      if (phase == 3) steady = 1'b1;
      if (phase == 5) now_ms = 32'hffff_ff00;                // run the clock through its wrap
      if (phase == 1 || phase == 2) begin
        queue_random(40);
      end else if (phase == 4) begin
        // receiver holds off while frames keep coming
        queue_random(100);
        holdoff_req = 1'b1;
      end else if (phase == 5) begin
        queue_random(50);
        wait_drained();
        queue_random(50);
      end else begin
        queue_random(100);
      end
      wait_drained();
      steady = 1'b0;
    end

    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
